[src/adamwu_pkg.sv]
// Types, constants and step functions for the Adam weight update pipeline.
`timescale 1ns / 1ps

package adamwu_pkg;

	localparam int DATA_W = 32;
	localparam int CFG_W  = 24;

	localparam logic [1:0] REG_BETA_FIRST  = 2'd0;
	localparam logic [1:0] REG_BETA_SECOND = 2'd1;
	localparam logic [1:0] REG_EPSILON     = 2'd2;
	localparam logic [1:0] REG_STEP        = 2'd3;

	localparam logic [CFG_W-1:0] BETA_FIRST_RST  = 24'd15099494;
	localparam logic [CFG_W-1:0] BETA_SECOND_RST = 24'd16760440;
	localparam logic [CFG_W-1:0] EPSILON_RST     = 24'd5628;
	localparam logic [CFG_W-1:0] STEP_RST        = 24'd16777;

	localparam logic [CFG_W:0] ONE_Q24 = 25'h100_0000;

	localparam int MDIV_STEPS = 40;
	localparam int VDIV_STEPS = 55;
	localparam int ROOT_STEPS = 40;
	localparam int QDIV_STEPS = 34;

	localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;
	localparam logic [30:0] VSAT_MAX = 31'h7FFF_FFFF;
	localparam logic [39:0] MHAT_MAX = 40'h7F_FFFF_FFFF;
	localparam logic [33:0] STEP_CAP = 34'h2_0000_0000;

	typedef struct packed {
		logic signed [31:0] weight_in;
		logic signed [31:0] first_moment_in;
		logic [30:0]        second_moment_in;
		logic signed [31:0] error_term;
		logic signed [31:0] activation;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] weight_out;
		logic signed [31:0] first_moment_out;
		logic [30:0]        second_moment_out;
		logic               saturated;
	} out_word_t;

	// values that ride along once the moments are known
	typedef struct packed {
		logic signed [31:0] w;
		logic signed [31:0] mn;
		logic [30:0]        vn;
		logic               flag;
	} carry_t;

	typedef struct packed {
		carry_t      c;
		logic [15:0] mlow;
		logic        movf;
		logic [24:0] mrem;
		logic [39:0] mq;
		logic [24:0] vrem;
		logic [54:0] vq;
	} div_t;

	typedef struct packed {
		carry_t      c;
		logic [39:0] mhat;
		logic [55:0] x;
		logic [41:0] rem;
		logic [39:0] root;
	} root_t;

	typedef struct packed {
		carry_t      c;
		logic [39:0] den;
		logic [33:0] nlow;
		logic        qovf;
		logic [39:0] rem;
		logic [33:0] qq;
	} qdiv_t;

	// one restoring division step, 25-bit divisor: {remainder, quotient bit}
	function automatic logic [25:0] div25_step(logic [24:0] rem, logic b, logic [24:0] d);
		logic [25:0] t;
		logic [25:0] diff;
		t = {rem, b};
		diff = t - {1'b0, d};
		if (t >= {1'b0, d}) begin
			return {diff[24:0], 1'b1};
		end
		return {t[24:0], 1'b0};
	endfunction

	// one restoring division step, 40-bit divisor
	function automatic logic [40:0] div40_step(logic [39:0] rem, logic b, logic [39:0] d);
		logic [40:0] t;
		logic [40:0] diff;
		t = {rem, b};
		diff = t - {1'b0, d};
		if (t >= {1'b0, d}) begin
			return {diff[39:0], 1'b1};
		end
		return {t[39:0], 1'b0};
	endfunction

	// one digit of the bitwise square root: {remainder, root bit}
	function automatic logic [42:0] root_step(logic [41:0] rem, logic [39:0] root,
			logic [1:0] pair);
		logic [43:0] t;
		logic [43:0] trial;
		logic [43:0] diff;
		t = {rem, pair};
		trial = {2'b00, root, 2'b01};
		diff = t - trial;
		if (t >= trial) begin
			return {diff[41:0], 1'b1};
		end
		return {t[41:0], 1'b0};
	endfunction

endpackage

[src/adam_weight_update.sv]
// Adam weight update: fully pipelined, one weight word per clock.
`timescale 1ns / 1ps

// Channel    | ports                                   | handshake
// input word | start, busy, din                        | taken when start=1 and busy=0
// result     | done, dout                              | one-cycle strobe, no backpressure
// config     | psel penable pwrite paddr pwdata prdata | APB write on access phase, pready=1
//
// done follows the word through s1-s6, dividers, root, s7, step divider and done_q.
// A new word may enter every cycle, so busy stays low.
// Depth is set by the bit-serial units: bias-correction dividers (v_hat 55 steps, m_hat 40),
// the Q8.24 square root (40 steps) and the step divider (34 steps), one step per stage.
// Reset clears the valid chain and loads the register defaults; payload is not reset.
// The receiver cannot stall, so no stage ever holds.
module adam_weight_update (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  adamwu_pkg::in_word_t  din,
	output logic                  done,
	output adamwu_pkg::out_word_t dout,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [3:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	// ---------------- configuration registers ----------------
	logic [23:0] beta_first_q, beta_second_q, epsilon_q, step_q;
	logic [24:0] om1, om2;	// 1 - beta in Q1.24, never zero

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_first_q  <= adamwu_pkg::BETA_FIRST_RST;
			beta_second_q <= adamwu_pkg::BETA_SECOND_RST;
			epsilon_q     <= adamwu_pkg::EPSILON_RST;
			step_q        <= adamwu_pkg::STEP_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				adamwu_pkg::REG_BETA_FIRST:  beta_first_q  <= pwdata[23:0];
				adamwu_pkg::REG_BETA_SECOND: beta_second_q <= pwdata[23:0];
				adamwu_pkg::REG_EPSILON:     epsilon_q     <= pwdata[23:0];
				adamwu_pkg::REG_STEP:        step_q        <= pwdata[23:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			adamwu_pkg::REG_BETA_FIRST:  prdata = {8'h00, beta_first_q};
			adamwu_pkg::REG_BETA_SECOND: prdata = {8'h00, beta_second_q};
			adamwu_pkg::REG_EPSILON:     prdata = {8'h00, epsilon_q};
			adamwu_pkg::REG_STEP:        prdata = {8'h00, step_q};
		endcase
	end

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign om1 = adamwu_pkg::ONE_Q24 - {1'b0, beta_first_q};
	assign om2 = adamwu_pkg::ONE_Q24 - {1'b0, beta_second_q};

	// ---------------- s1: gradient and decay products ----------------
	logic               vld_s1;
	logic signed [63:0] p_ea_s1;
	logic signed [56:0] p_bm_s1;
	logic [54:0]        p_bv_s1;
	logic signed [31:0] w_s1;

	always_ff @(posedge clk) begin
		p_ea_s1 <= din.error_term * din.activation;
		p_bm_s1 <= $signed({1'b0, beta_first_q}) * din.first_moment_in;
		p_bv_s1 <= beta_second_q * din.second_moment_in;
		w_s1    <= din.weight_in;
	end

	// ---------------- s2: gradient, floor and clip ----------------
	logic               vld_s2;
	logic signed [31:0] g_s2;
	logic               flag_s2;
	logic signed [56:0] p_bm_s2;
	logic [54:0]        p_bv_s2;
	logic signed [31:0] w_s2;
	logic [39:0]        gs;
	logic               g_ovf;

	assign gs    = p_ea_s1[63:24];
	assign g_ovf = !((&gs[39:31]) || !(|gs[39:31]));

	always_ff @(posedge clk) begin
		if (g_ovf) begin
			g_s2 <= gs[39] ? adamwu_pkg::SAT_MIN : adamwu_pkg::SAT_MAX;
		end else begin
			g_s2 <= gs[31:0];
		end
		flag_s2 <= g_ovf;
		p_bm_s2 <= p_bm_s1;
		p_bv_s2 <= p_bv_s1;
		w_s2    <= w_s1;
	end

	// ---------------- s3: (1-b1)*g and g squared ----------------
	logic               vld_s3;
	logic signed [57:0] p_og_s3;
	logic [63:0]        usq_s3;
	logic signed [56:0] p_bm_s3;
	logic [54:0]        p_bv_s3;
	logic signed [31:0] w_s3;
	logic               flag_s3;
	logic [31:0]        ug;

	assign ug = g_s2[31] ? 32'(-g_s2) : g_s2;

	always_ff @(posedge clk) begin
		p_og_s3 <= $signed({1'b0, om1}) * g_s2;
		usq_s3  <= ug * ug;
		p_bm_s3 <= p_bm_s2;
		p_bv_s3 <= p_bv_s2;
		w_s3    <= w_s2;
		flag_s3 <= flag_s2;
	end

	// ---------------- s4: new first moment ----------------
	logic               vld_s4;
	logic signed [31:0] mn_s4;
	logic [38:0]        gsq_s4;
	logic [54:0]        p_bv_s4;
	logic signed [31:0] w_s4;
	logic               flag_s4;
	logic signed [58:0] msum;
	logic [34:0]        ms;
	logic               m_ovf;

	assign msum  = 59'(p_bm_s3) + 59'(p_og_s3);
	assign ms    = msum[58:24];
	assign m_ovf = !((&ms[34:31]) || !(|ms[34:31]));

	always_ff @(posedge clk) begin
		if (m_ovf) begin
			mn_s4 <= ms[34] ? adamwu_pkg::SAT_MIN : adamwu_pkg::SAT_MAX;
		end else begin
			mn_s4 <= ms[31:0];
		end
		gsq_s4  <= usq_s3[62:24];
		p_bv_s4 <= p_bv_s3;
		w_s4    <= w_s3;
		flag_s4 <= flag_s3 | m_ovf;
	end

	// ---------------- s5: (1-b2)*gsq in two partial products ----------------
	logic               vld_s5;
	logic [44:0]        pv_lo_s5;
	logic [43:0]        pv_hi_s5;
	logic [54:0]        p_bv_s5;
	logic signed [31:0] mn_s5;
	logic signed [31:0] w_s5;
	logic               flag_s5;

	always_ff @(posedge clk) begin
		pv_lo_s5 <= om2 * gsq_s4[19:0];
		pv_hi_s5 <= om2 * gsq_s4[38:20];
		p_bv_s5  <= p_bv_s4;
		mn_s5    <= mn_s4;
		w_s5     <= w_s4;
		flag_s5  <= flag_s4;
	end

	// ---------------- s6: new second moment ----------------
	logic               vld_s6;
	logic [30:0]        vn_s6;
	logic signed [31:0] mn_s6;
	logic signed [31:0] w_s6;
	logic               flag_s6;
	logic [64:0]        vacc;
	logic [40:0]        vs;
	logic               v_ovf;

	assign vacc  = 65'(p_bv_s5) + 65'(pv_lo_s5) + {1'b0, pv_hi_s5, 20'h00000};
	assign vs    = vacc[64:24];
	assign v_ovf = |vs[40:31];

	always_ff @(posedge clk) begin
		vn_s6   <= v_ovf ? adamwu_pkg::VSAT_MAX : vs[30:0];
		mn_s6   <= mn_s5;
		w_s6    <= w_s5;
		flag_s6 <= flag_s5 | v_ovf;
	end

	// ---------------- bias correction dividers ----------------
	// m_hat = |m'|<<24 / (1-b1), 40 quotient bits after an overflow check;
	// v_hat = v'<<24 / (1-b2), all 55 quotient bits. One step per stage.
	adamwu_pkg::div_t div_s [0:adamwu_pkg::VDIV_STEPS];
	logic [adamwu_pkg::VDIV_STEPS:0] dvld_s;
	logic [31:0] mag;

	assign mag = mn_s6[31] ? 32'(-mn_s6) : mn_s6;

	always_ff @(posedge clk) begin
		div_s[0].c.w    <= w_s6;
		div_s[0].c.mn   <= mn_s6;
		div_s[0].c.vn   <= vn_s6;
		div_s[0].c.flag <= flag_s6;
		div_s[0].mlow   <= mag[15:0];
		div_s[0].movf   <= {8'h00, mag} >= {om1, 15'h0000};
		div_s[0].mrem   <= {9'h000, mag[31:16]};
		div_s[0].mq     <= '0;
		div_s[0].vrem   <= '0;
		div_s[0].vq     <= '0;
	end

	for (genvar k = 0; k < adamwu_pkg::VDIV_STEPS; k++) begin : g_div
		logic        vbit, mbit;
		logic [25:0] vstep, mstep;

		if (k < 31) begin : g_vb
			assign vbit = div_s[k].c.vn[30-k];
		end else begin : g_vz
			assign vbit = 1'b0;
		end
		if (k < 16) begin : g_mb
			assign mbit = div_s[k].mlow[15-k];
		end else begin : g_mz
			assign mbit = 1'b0;
		end

		assign vstep = adamwu_pkg::div25_step(div_s[k].vrem, vbit, om2);
		assign mstep = adamwu_pkg::div25_step(div_s[k].mrem, mbit, om1);

		always_ff @(posedge clk) begin
			div_s[k+1].c    <= div_s[k].c;
			div_s[k+1].mlow <= div_s[k].mlow;
			div_s[k+1].movf <= div_s[k].movf;
			div_s[k+1].vrem <= vstep[25:1];
			div_s[k+1].vq   <= {div_s[k].vq[53:0], vstep[0]};
			if (k < adamwu_pkg::MDIV_STEPS) begin
				div_s[k+1].mrem <= mstep[25:1];
				div_s[k+1].mq   <= {div_s[k].mq[38:0], mstep[0]};
			end else begin
				div_s[k+1].mrem <= div_s[k].mrem;
				div_s[k+1].mq   <= div_s[k].mq;
			end
		end
	end

	// ---------------- square root of (v_hat + eps) in Q8.24 ----------------
	adamwu_pkg::root_t root_s [0:adamwu_pkg::ROOT_STEPS];
	logic [adamwu_pkg::ROOT_STEPS:0] rvld_s;
	adamwu_pkg::div_t  dlast;

	assign dlast = div_s[adamwu_pkg::VDIV_STEPS];

	always_ff @(posedge clk) begin
		root_s[0].c.w    <= dlast.c.w;
		root_s[0].c.mn   <= dlast.c.mn;
		root_s[0].c.vn   <= dlast.c.vn;
		root_s[0].c.flag <= dlast.c.flag | dlast.movf;
		root_s[0].mhat   <= dlast.movf ? adamwu_pkg::MHAT_MAX : dlast.mq;
		root_s[0].x      <= {1'b0, dlast.vq} + {32'h0000_0000, epsilon_q};
		root_s[0].rem    <= '0;
		root_s[0].root   <= '0;
	end

	for (genvar k = 0; k < adamwu_pkg::ROOT_STEPS; k++) begin : g_root
		logic [1:0]  pair;
		logic [42:0] rstep;

		// radicand is x<<24: the low 24 bits bring zero pairs
		if (k <= 27) begin : g_pr
			assign pair = root_s[k].x[54-2*k +: 2];
		end else begin : g_pz
			assign pair = 2'b00;
		end

		assign rstep = adamwu_pkg::root_step(root_s[k].rem, root_s[k].root, pair);

		always_ff @(posedge clk) begin
			root_s[k+1].c    <= root_s[k].c;
			root_s[k+1].mhat <= root_s[k].mhat;
			root_s[k+1].x    <= root_s[k].x;
			root_s[k+1].rem  <= rstep[42:1];
			root_s[k+1].root <= {root_s[k].root[38:0], rstep[0]};
		end
	end

	// ---------------- s7: m_hat * step in two partial products ----------------
	adamwu_pkg::root_t  rlast;
	logic               vld_s7;
	logic [43:0]        pm_lo_s7, pm_hi_s7;
	logic [39:0]        den_s7;
	adamwu_pkg::carry_t c_s7;

	assign rlast = root_s[adamwu_pkg::ROOT_STEPS];

	always_ff @(posedge clk) begin
		pm_lo_s7 <= rlast.mhat[19:0] * step_q;
		pm_hi_s7 <= rlast.mhat[39:20] * step_q;
		den_s7   <= (rlast.root == '0) ? 40'd1 : rlast.root;
		c_s7     <= rlast.c;
	end

	// ---------------- step divider: q = m_hat*step / den ----------------
	adamwu_pkg::qdiv_t qdiv_s [0:adamwu_pkg::QDIV_STEPS];
	logic [adamwu_pkg::QDIV_STEPS:0] qvld_s;
	logic [63:0] num;

	assign num = {20'h00000, pm_lo_s7} + {pm_hi_s7, 20'h00000};

	always_ff @(posedge clk) begin
		qdiv_s[0].c    <= c_s7;
		qdiv_s[0].den  <= den_s7;
		qdiv_s[0].nlow <= num[33:0];
		qdiv_s[0].qovf <= {10'h000, num[63:34]} >= den_s7;	// quotient >= 2^34
		qdiv_s[0].rem  <= {10'h000, num[63:34]};
		qdiv_s[0].qq   <= '0;
	end

	for (genvar k = 0; k < adamwu_pkg::QDIV_STEPS; k++) begin : g_qdiv
		logic [40:0] qstep;

		assign qstep = adamwu_pkg::div40_step(qdiv_s[k].rem, qdiv_s[k].nlow[33-k],
			qdiv_s[k].den);

		always_ff @(posedge clk) begin
			qdiv_s[k+1].c    <= qdiv_s[k].c;
			qdiv_s[k+1].den  <= qdiv_s[k].den;
			qdiv_s[k+1].nlow <= qdiv_s[k].nlow;
			qdiv_s[k+1].qovf <= qdiv_s[k].qovf;
			qdiv_s[k+1].rem  <= qstep[40:1];
			qdiv_s[k+1].qq   <= {qdiv_s[k].qq[32:0], qstep[0]};
		end
	end

	// ---------------- output: apply step, clip ----------------
	adamwu_pkg::qdiv_t  qlast;
	logic [33:0]        qstep_mag;
	logic signed [35:0] wn;
	logic               w_ovf;
	logic               done_q;
	adamwu_pkg::out_word_t dout_q;

	assign qlast = qdiv_s[adamwu_pkg::QDIV_STEPS];
	assign qstep_mag = (qlast.qovf || (qlast.qq > adamwu_pkg::STEP_CAP)) ?
		adamwu_pkg::STEP_CAP : qlast.qq;
	// move against the sign of the first moment
	assign wn = qlast.c.mn[31] ? (36'(qlast.c.w) + $signed({2'b00, qstep_mag})) :
		(36'(qlast.c.w) - $signed({2'b00, qstep_mag}));
	assign w_ovf = !((&wn[35:31]) || !(|wn[35:31]));

	always_ff @(posedge clk) begin
		if (w_ovf) begin
			dout_q.weight_out <= wn[35] ? adamwu_pkg::SAT_MIN : adamwu_pkg::SAT_MAX;
		end else begin
			dout_q.weight_out <= wn[31:0];
		end
		dout_q.first_moment_out  <= qlast.c.mn;
		dout_q.second_moment_out <= qlast.c.vn;
		dout_q.saturated         <= qlast.c.flag | w_ovf;
	end

	// ---------------- valid chain ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			dvld_s <= '0;
			rvld_s <= '0;
			vld_s7 <= 1'b0;
			qvld_s <= '0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			dvld_s <= {dvld_s[adamwu_pkg::VDIV_STEPS-1:0], vld_s6};
			rvld_s <= {rvld_s[adamwu_pkg::ROOT_STEPS-1:0], dvld_s[adamwu_pkg::VDIV_STEPS]};
			vld_s7 <= rvld_s[adamwu_pkg::ROOT_STEPS];
			qvld_s <= {qvld_s[adamwu_pkg::QDIV_STEPS-1:0], vld_s7};
			done_q <= qvld_s[adamwu_pkg::QDIV_STEPS];
		end
	end

	assign done = done_q;
	assign dout = dout_q;

endmodule
